### rtl/button_hold_combo_decoder_defines.svh
// Assertion macros for the button hold/combo decoder.
// Included by the RTL module that carries concurrent checks; no dependencies.
`ifndef BUTTON_HOLD_COMBO_DECODER_DEFINES_SVH
`define BUTTON_HOLD_COMBO_DECODER_DEFINES_SVH

`ifndef SYNTHESIS
`define BHCD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define BHCD_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");
`else
`define BHCD_ASSERT(lbl, clk, rstn, prop)
`define BHCD_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

### rtl/bhcd_pkg.sv
// Shared types, key codes and the button-mask lookup for the hold/combo decoder.
// No dependencies.
package bhcd_pkg;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_PRESSED = 2'd1,
    ST_HELD    = 2'd2,
    ST_WAIT    = 2'd3
  } bhcd_state_e;

  localparam logic [2:0] CODE_A    = 3'd0;
  localparam logic [2:0] CODE_B    = 3'd1;
  localparam logic [2:0] CODE_X    = 3'd2;
  localparam logic [2:0] CODE_Y    = 3'd3;
  localparam logic [2:0] CODE_BACK = 3'd4;
  localparam logic [2:0] CODE_NONE = 3'd7;

  localparam logic [3:0] MASK_A    = 4'b0001;
  localparam logic [3:0] MASK_B    = 4'b0010;
  localparam logic [3:0] MASK_X    = 4'b0100;
  localparam logic [3:0] MASK_Y    = 4'b1000;
  localparam logic [3:0] MASK_BACK = 4'b1010;

  localparam logic [15:0] HOLD_COUNT_RST = 16'd50;

  // mask bit order: 0 A, 1 B, 2 X, 3 Y
  function automatic logic [2:0] lookup_code(input logic [3:0] mask);
    logic [2:0] code;
    case (mask)
      MASK_A:    code = CODE_A;
      MASK_B:    code = CODE_B;
      MASK_X:    code = CODE_X;
      MASK_Y:    code = CODE_Y;
      MASK_BACK: code = CODE_BACK;
      default:   code = CODE_NONE;
    endcase
    return code;
  endfunction

endpackage

### rtl/button_hold_combo_decoder.sv
// Top level of the button hold/combo decoder: edge detect, hold timer, state machine
// and a two-entry result buffer. Depends on bhcd_pkg and the assertion macro header.
`include "button_hold_combo_decoder_defines.svh"

// One polling tick per request, one request per clock cycle. A tick is decoded in
// the cycle it is accepted: the state machine and hold counter update at that edge
// and a key event, if any, lands in a two-entry output buffer, so key_code_o is
// valid from the next cycle. Input stalls only when both buffer entries are
// occupied, which takes a downstream stall while an earlier event still waits.
// hold_count_q is loaded into the hold counter on the first press seen in idle;
// a write while a counter runs takes effect at the next press. A hold count of
// zero fires after 65536 ticks.
module button_hold_combo_decoder
  import bhcd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        press_a_i,
  input  logic        press_b_i,
  input  logic        press_x_i,
  input  logic        press_y_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  key_code_o
);

  bhcd_state_e state_q, state_d;
  logic [3:0]  prev_q, prev_d;
  logic [15:0] hold_cnt_q, hold_cnt_d;
  logic [15:0] hold_count_q;
  logic [2:0]  latched_q, latched_d;

  logic [3:0]  cur, rising, falling, fall_bit;
  logic [15:0] hold_dec;
  logic [2:0]  rel_code, cur_code;
  logic        in_acc;
  logic        push;
  logic [2:0]  push_code;

  // two-entry result buffer
  logic [2:0]  buf_q [2];
  logic [1:0]  cnt_q, cnt_d;
  logic        wr_q, rd_q;
  logic        pop;

  assign in_stall_o  = (cnt_q == 2'd2);
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign out_valid_o = (cnt_q != 2'd0);
  assign key_code_o  = buf_q[rd_q];
  assign pop         = out_valid_o & ~out_stall_i;

  assign cur      = {press_y_i, press_x_i, press_b_i, press_a_i};
  assign rising   = cur & ~prev_q;
  assign falling  = ~cur & prev_q;
  assign fall_bit = falling & (4'd0 - falling);  // lowest released button wins
  assign rel_code = lookup_code(cur | fall_bit);
  assign cur_code = lookup_code(cur);
  assign hold_dec = hold_cnt_q - 16'd1;

  always_comb begin
    state_d    = state_q;
    prev_d     = prev_q;
    hold_cnt_d = hold_cnt_q;
    latched_d  = latched_q;
    push       = 1'b0;
    push_code  = CODE_NONE;
    if (in_acc) begin
      prev_d = cur;
      case (state_q)
        ST_IDLE: begin
          if (rising != 4'd0) begin
            hold_cnt_d = hold_count_q;
            state_d    = ST_PRESSED;
          end
        end
        ST_PRESSED: begin
          if (falling != 4'd0) begin
            push      = (rel_code != CODE_NONE);
            push_code = rel_code;
            state_d   = (rel_code == CODE_BACK) ? ST_WAIT : ST_IDLE;
          end else begin
            hold_cnt_d = hold_dec;
            if (hold_dec == 16'd0) begin
              latched_d = cur_code;
              push      = (cur_code != CODE_NONE);
              push_code = cur_code;
              state_d   = ST_HELD;
            end
          end
        end
        ST_HELD: begin
          if (falling != 4'd0) begin
            push      = (latched_q != CODE_NONE);
            push_code = latched_q;
            state_d   = ST_IDLE;
          end
        end
        ST_WAIT: begin
          // button A does not hold off the return to idle
          if (cur[3:1] == 3'd0) begin
            state_d = ST_IDLE;
          end
        end
        default: state_d = ST_IDLE;
      endcase
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      prev_q       <= 4'd0;
      hold_cnt_q   <= HOLD_COUNT_RST;
      hold_count_q <= HOLD_COUNT_RST;
      latched_q    <= CODE_NONE;
      cnt_q        <= 2'd0;
      wr_q         <= 1'b0;
      rd_q         <= 1'b0;
    end else begin
      state_q    <= state_d;
      prev_q     <= prev_d;
      hold_cnt_q <= hold_cnt_d;
      latched_q  <= latched_d;
      cnt_q      <= cnt_d;
      if (cfg_we_i) begin
        hold_count_q <= cfg_wdata_i;
      end
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_q] <= push_code;
    end
  end

  `BHCD_ASSERT_NEVER(a_cnt_range, clk_i, rst_ni, cnt_q == 2'd3)
  `BHCD_ASSERT_NEVER(a_no_none_push, clk_i, rst_ni, push && (push_code == CODE_NONE))
  `BHCD_ASSERT_NEVER(a_push_when_full, clk_i, rst_ni, push && (cnt_q == 2'd2))
  `BHCD_ASSERT(a_wait_after_back, clk_i, rst_ni,
    (in_acc && (state_q == ST_PRESSED) && (state_d == ST_WAIT)) |=> (cnt_q != 2'd0))
  `BHCD_ASSERT(a_held_entry_pushes, clk_i, rst_ni,
    (state_q == ST_HELD && $past(state_q) == ST_PRESSED && $past(latched_d) != CODE_NONE)
      |-> ($past(push) && $past(push_code) == latched_q))

endmodule
